/* design/mfle_pkg.sv */
`default_nettype none

package mfle_pkg;

    localparam int BURST_MAX = 8;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
    localparam int BURST_IDX_W = $clog2(BURST_MAX);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    // bytes produced by one input, sent in order from index 0
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_CNT_W-1:0]    cnt;
    } burst_t;

    // the "From " pattern, one byte per position
    function automatic logic [7:0] pat_byte(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/mbox_from_line_escaper.sv */
`default_nettype none

// mboxrd "From " quoting, one message byte per transfer. Lines whose text
// (after any run of '>') begins with "From " get one extra '>' in front.
// Up to four matching bytes are held until the line prefix is decided;
// such bytes produce no output on their own. A finish request (req_type 1)
// flushes held bytes, ends an open line with CRLF and adds a blank CRLF line.
// Each input gives 0 to 8 output bytes, m_last marking the final one. An
// input is taken every cycle while inputs yield at most one byte each and
// m_ready is high; the single output byte port sets the rate, so an input
// yielding several bytes holds the stream until all are sent. A one-burst
// skid slot lets the next input enter while the current burst is being sent.
module mbox_from_line_escaper
    import mfle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last
);

    typedef enum logic [1:0] {
        PH_FRESH  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_MID    = 2'd2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  mcount_reg;
    logic [2:0]  mcount_next;
    logic [2:0]  m;
    burst_t      burst;
    logic        accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        m           = (mcount_reg > 3'd4) ? 3'd0 : mcount_reg;
        burst       = '0;
        phase_next  = phase_reg;
        mcount_next = 3'd0;
        if (s_req_type) begin
            for (int i = 0; i < BURST_MAX; i++) begin
                if (3'(i) < m) begin
                    burst.bytes[i] = pat_byte(3'(i));
                end else begin
                    // tail alternates CR, LF
                    burst.bytes[i] = (i[0] ^ m[0]) ? CHAR_LF : CHAR_CR;
                end
            end
            burst.cnt  = BURST_CNT_W'(m) +
                         ((phase_reg != PH_FRESH) ? BURST_CNT_W'(4) : BURST_CNT_W'(2));
            phase_next = PH_FRESH;
        end else if (phase_reg != PH_FRESH && phase_reg != PH_PREFIX) begin
            burst.bytes[0] = s_in_byte;
            burst.cnt      = BURST_CNT_W'(1);
            if (s_in_byte == CHAR_LF) begin
                phase_next = PH_FRESH;
            end
        end else if (m == 3'd0 && s_in_byte == CHAR_GT) begin
            burst.bytes[0] = s_in_byte;
            burst.cnt      = BURST_CNT_W'(1);
            phase_next     = PH_PREFIX;
        end else if (s_in_byte == pat_byte(m)) begin
            if (m == 3'd4) begin
                burst.bytes[0] = CHAR_GT;
                for (int i = 0; i < 5; i++) begin
                    burst.bytes[i+1] = pat_byte(3'(i));
                end
                burst.cnt  = BURST_CNT_W'(6);
                phase_next = PH_MID;
            end else begin
                // hold the byte, nothing sent yet
                phase_next  = PH_PREFIX;
                mcount_next = m + 3'd1;
            end
        end else begin
            for (int i = 0; i < BURST_MAX; i++) begin
                if (3'(i) < m) begin
                    burst.bytes[i] = pat_byte(3'(i));
                end else if (3'(i) == m) begin
                    burst.bytes[i] = s_in_byte;
                end
            end
            burst.cnt  = BURST_CNT_W'(m) + BURST_CNT_W'(1);
            phase_next = (s_in_byte == CHAR_LF) ? PH_FRESH : PH_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FRESH;
            mcount_reg <= 3'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            mcount_reg <= mcount_next;
        end
    end

    mfle_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept && (burst.cnt != '0)),
        .burst_in   (burst),
        .load_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    a_mcount_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mcount_reg <= 3'd4)
        else $error("match count out of range");

    a_held_in_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (mcount_reg != 3'd0) |-> (phase_reg == PH_PREFIX))
        else $error("held bytes outside line prefix");

    a_finish_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type) |=> (phase_reg == PH_FRESH && mcount_reg == 3'd0))
        else $error("finish did not return to line start");

endmodule

`default_nettype wire

/* design/mfle_ser.sv */
`default_nettype none

module mfle_ser
    import mfle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire burst_t     burst_in,
    output logic            load_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last
);

    burst_t                 act_reg;
    logic                   act_valid_reg;
    logic [BURST_IDX_W-1:0] idx_reg;
    burst_t                 pend_reg;
    logic                   pend_valid_reg;

    logic act_last;
    logic act_done;
    logic act_free;

    assign act_last = ((BURST_CNT_W'(idx_reg) + BURST_CNT_W'(1)) == act_reg.cnt);
    assign act_done = act_valid_reg && m_ready && act_last;
    assign act_free = !act_valid_reg || act_done;

    // skid slot keeps ready a plain register
    assign load_ready = !pend_valid_reg;

    assign m_valid    = act_valid_reg;
    assign m_out_byte = act_reg.bytes[idx_reg];
    assign m_last     = act_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (act_free) begin
                if (pend_valid_reg) begin
                    act_reg        <= pend_reg;
                    act_valid_reg  <= 1'b1;
                    idx_reg        <= '0;
                    pend_valid_reg <= 1'b0;
                end else if (load) begin
                    act_reg       <= burst_in;
                    act_valid_reg <= 1'b1;
                    idx_reg       <= '0;
                end else begin
                    act_valid_reg <= 1'b0;
                end
            end else begin
                if (m_valid && m_ready) begin
                    idx_reg <= idx_reg + BURST_IDX_W'(1);
                end
                if (load) begin
                    pend_reg       <= burst_in;
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    a_pend_needs_act: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> act_valid_reg)
        else $error("skid slot filled while output idle");

    a_act_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        act_valid_reg |-> (act_reg.cnt != '0) && (BURST_CNT_W'(idx_reg) < act_reg.cnt))
        else $error("output index outside burst");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte) && $stable(m_last)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

/* test/tb_mbox_from_line_escaper.sv */
`timescale 1ns / 100ps

module tb_mbox_from_line_escaper;
    import mfle_pkg::*;

    localparam logic [0:4][7:0] FROM_SEQ = "From ";
    localparam int TOTAL_ITEMS = 425;

    typedef enum logic [1:0] {LINE_FRESH, LINE_PREFIX, LINE_MID} line_pos_t;

    typedef logic [7:0] burst_bytes_t [8];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // n < 0 means the expected bytes come from the predictor
    typedef struct packed {
        logic        req;
        logic [7:0]  data;
        int          n;
        logic [63:0] exp;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;

    line_pos_t   line_pos = LINE_FRESH;
    int          held_cnt = 0;
    out_beat_t   pending_beats [$];
    int          mismatch_cnt = 0;
    int          sent_cnt = 0;
    int          row_exp_n = -1;
    logic [63:0] row_exp = '0;
    int          tx_quiet = 0;
    int          rx_quiet = 0;
    int          rx_hold = 0;
    bit          drained_once = 1'b0;

    row_t directed_rows [25] = '{
        '{1'b1, 8'h00, 2, "\r\n"},
        '{1'b0, 8'h00, 1, 64'h00},
        '{1'b0, 8'hFF, 1, 64'hFF},
        '{1'b0, "\n", 1, "\n"},
        '{1'b0, ">", 1, ">"},
        '{1'b0, "F", 0, 64'h0},
        '{1'b0, "r", 0, 64'h0},
        '{1'b0, "o", 0, 64'h0},
        '{1'b0, "m", 0, 64'h0},
        '{1'b0, " ", 6, ">From "},
        '{1'b0, "\n", -1, 64'h0},
        '{1'b0, "F", 0, 64'h0},
        '{1'b0, "r", 0, 64'h0},
        '{1'b0, ">", 3, "Fr>"},
        '{1'b1, 8'h00, 4, "\r\n\r\n"},
        '{1'b0, "F", 0, 64'h0},
        '{1'b0, "r", 0, 64'h0},
        '{1'b0, "o", 0, 64'h0},
        '{1'b0, "m", 0, 64'h0},
        '{1'b1, 8'h00, 8, "From\r\n\r\n"},
        '{1'b0, ">", 1, ">"},
        '{1'b1, 8'h00, 4, "\r\n\r\n"},
        '{1'b0, "F", 0, 64'h0},
        '{1'b0, "\n", 2, "F\n"},
        '{1'b1, 8'hFF, 2, "\r\n"}
    };

    mbox_from_line_escaper dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // escaped bytes for one request, advancing the line state
    function automatic void quote_byte(input logic req, input logic [7:0] b,
                                       output burst_bytes_t outs, output int n);
        n = 0;
        outs = '{default: 8'h00};
        if (req) begin
            for (int i = 0; i < held_cnt; i++) begin
                outs[n] = FROM_SEQ[i];
                n++;
            end
            if (line_pos != LINE_FRESH) begin
                outs[n] = CHAR_CR;
                outs[n+1] = CHAR_LF;
                n += 2;
            end
            outs[n] = CHAR_CR;
            outs[n+1] = CHAR_LF;
            n += 2;
            line_pos = LINE_FRESH;
            held_cnt = 0;
        end else if (line_pos == LINE_MID) begin
            outs[0] = b;
            n = 1;
            if (b == CHAR_LF)
                line_pos = LINE_FRESH;
            held_cnt = 0;
        end else if (held_cnt == 0 && b == CHAR_GT) begin
            outs[0] = b;
            n = 1;
            line_pos = LINE_PREFIX;
        end else if (b == FROM_SEQ[held_cnt]) begin
            if (held_cnt == 4) begin
                outs[0] = CHAR_GT;
                for (int i = 0; i < 5; i++)
                    outs[i+1] = FROM_SEQ[i];
                n = 6;
                line_pos = LINE_MID;
                held_cnt = 0;
            end else begin
                line_pos = LINE_PREFIX;
                held_cnt++;
            end
        end else begin
            for (int i = 0; i < held_cnt; i++) begin
                outs[n] = FROM_SEQ[i];
                n++;
            end
            outs[n] = b;
            n++;
            line_pos = (b == CHAR_LF) ? LINE_FRESH : LINE_MID;
            held_cnt = 0;
        end
    endfunction

    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    // input and output transfers are handled in one process so that a
    // result can never be seen before its expectation is queued
    always @(posedge aclk) begin
        burst_bytes_t pb;
        int           pn;
        out_beat_t    want;
        if (aresetn && s_valid && s_ready) begin
            quote_byte(s_req_type, s_in_byte, pb, pn);
            if (row_exp_n >= 0) begin
                pn = row_exp_n;
                for (int i = 0; i < pn; i++)
                    pb[i] = row_exp[8*(pn-1-i) +: 8];
            end
            for (int i = 0; i < pn; i++)
                pending_beats.push_back('{data: pb[i], last: (i == pn - 1)});
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                flag_error($sformatf("unexpected output byte %02h last %0b",
                                     m_out_byte, m_last));
            end else begin
                want = pending_beats.pop_front();
                if (want.data !== m_out_byte || want.last !== m_last)
                    flag_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                         want.data, m_out_byte, want.last, m_last));
            end
        end
    end

    always @(negedge aclk) begin
        int gap;
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            gap = idle_len(rx_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                rx_hold = gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic req, input logic [7:0] data,
                             input int n, input logic [63:0] exp);
        int gap;
        gap = idle_len(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_in_byte  <= data;
        row_exp_n  <= n;
        row_exp    <= exp;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
        @(negedge aclk);
    endtask

    task automatic send_data(input logic [7:0] data);
        send_item(1'b0, data, -1, 64'h0);
    endtask

    task automatic drain_all();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_beats.size() != 0);
    endtask

    // one line: optional quote run, then a full, partial or absent "From "
    task automatic random_line();
        int kind;
        int len;
        int r;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_data(CHAR_GT);
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            for (int i = 0; i < 5; i++)
                send_data(FROM_SEQ[i]);
        end else if (kind < 7) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_data(FROM_SEQ[i]);
            send_data(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 5)) send_data(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 9);
        if (r < 7)
            send_data(CHAR_LF);
        else if (r < 9)
            send_item(1'b1, 8'($urandom_range(0, 255)), -1, 64'h0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].data,
                      directed_rows[i].n, directed_rows[i].exp);

        while (sent_cnt < TOTAL_ITEMS) begin
            if ((!drained_once && sent_cnt >= 200) || $urandom_range(0, 49) == 0) begin
                drain_all();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          -1, 64'h0);
            else
                random_line();
        end
        s_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
